FILE: rtl/core/clip_stack_rect_clipper_assert.svh
// Assertion macros for the clip stack checker
`ifndef CLIP_STACK_RECT_CLIPPER_ASSERT_SVH
`define CLIP_STACK_RECT_CLIPPER_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define CSRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define CSRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/csrc_pkg.sv
package csrc_pkg;

    localparam int COORD_W      = 13;
    localparam int SUM_W        = 15;
    localparam int EDGE_W       = 13;
    localparam int OUT_EDGE_W   = 12;
    localparam int COLOR_W      = 32;
    localparam int REQ_W        = 3;
    localparam int DEPTH_OUT_W  = 4;
    localparam int SCR_W_W      = 11;
    localparam int SCR_H_W      = 10;
    localparam int S_TDATA_W    = 120;
    localparam int S_TUSER_W    = 3;
    localparam int M_TDATA_W    = 120;
    localparam int M_TUSER_W    = 1;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int QUEUE_DEPTH  = 2;

    localparam int DEF_CLIP_DEPTH = 8;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 768;

    localparam logic [SCR_W_W-1:0] SCR_W_RESET = 11'd1024;
    localparam logic [SCR_H_W-1:0] SCR_H_RESET = 10'd768;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

    localparam logic [REQ_W-1:0] REQ_PUSH    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_VISIBLE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_PIXEL   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FILL    = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DITHER  = 3'd5;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_POP,
        OP_VISIBLE,
        OP_PIXEL,
        OP_FILL,
        OP_DITHER,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic signed [SUM_W-1:0]   x;
        logic signed [SUM_W-1:0]   y;
        logic signed [SUM_W-1:0]   x2;
        logic signed [SUM_W-1:0]   y2;
        logic [COLOR_W-1:0]        ca;
        logic [COLOR_W-1:0]        cb;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [EDGE_W-1:0] l;
        logic [EDGE_W-1:0] t;
        logic [EDGE_W-1:0] r;
        logic [EDGE_W-1:0] b;
    } edge_rect_t;

    typedef struct packed {
        logic [EDGE_W-1:0] width;
        logic [EDGE_W-1:0] height;
    } screen_t;

    typedef struct packed {
        logic                    hit;
        logic [OUT_EDGE_W-1:0]   l;
        logic [OUT_EDGE_W-1:0]   t;
        logic [OUT_EDGE_W-1:0]   r;
        logic [OUT_EDGE_W-1:0]   b;
        logic [COLOR_W-1:0]      ca;
        logic [COLOR_W-1:0]      cb;
        logic                    dith;
        logic [DEPTH_OUT_W-1:0]  depth;
    } result_t;

endpackage

FILE: rtl/core/csrc_front.sv
module csrc_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [csrc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [csrc_pkg::S_TUSER_W-1:0] s_tuser,
    input  csrc_pkg::q_status_t           q_status,
    output logic                          q_push,
    output csrc_pkg::cmd_t                q_cmd
);
    import csrc_pkg::*;

    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] size_w;
    logic signed [COORD_W-1:0] size_h;
    op_t                       op;

    assign pos_x  = s_tdata[12:0];
    assign pos_y  = s_tdata[25:13];
    assign size_w = s_tdata[38:26];
    assign size_h = s_tdata[51:39];

    always_comb begin
        case (s_tuser)
            REQ_PUSH:    op = OP_PUSH;
            REQ_POP:     op = OP_POP;
            REQ_VISIBLE: op = OP_VISIBLE;
            REQ_PIXEL:   op = OP_PIXEL;
            REQ_FILL:    op = OP_FILL;
            REQ_DITHER:  op = OP_DITHER;
            default:     op = OP_NONE;
        endcase
    end

    always_comb begin
        q_cmd.op = op;
        q_cmd.x  = SUM_W'(pos_x);
        q_cmd.y  = SUM_W'(pos_y);
        q_cmd.x2 = SUM_W'(pos_x) + SUM_W'(size_w);
        q_cmd.y2 = SUM_W'(pos_y) + SUM_W'(size_h);
        q_cmd.ca = s_tdata[83:52];
        q_cmd.cb = s_tdata[115:84];
    end

    assign s_tready = !q_status.full;
    assign q_push   = s_tvalid;

endmodule

FILE: rtl/core/csrc_queue.sv
module csrc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  csrc_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output csrc_pkg::cmd_t      head_cmd,
    output csrc_pkg::q_status_t status
);
    import csrc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_ok;
    logic             pop_ok;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign push_ok      = push && !status.full;
    assign pop_ok       = pop && !status.empty;
    assign head_cmd     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !pop_ok) begin
            count_next = count_reg + 1'b1;
        end else if (pop_ok && !push_ok) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/core/csrc_back.sv
module csrc_back #(
    parameter int CLIP_DEPTH = csrc_pkg::DEF_CLIP_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  csrc_pkg::screen_t   screen,
    input  csrc_pkg::q_status_t q_status,
    input  csrc_pkg::cmd_t      cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output csrc_pkg::result_t   m_result
);
    import csrc_pkg::*;

    localparam int CNT_W     = $clog2(CLIP_DEPTH + 1);
    localparam int MEM_DEPTH = (CLIP_DEPTH > 2) ? CLIP_DEPTH - 2 : 1;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    edge_rect_t        mem [MEM_DEPTH];
    logic [CNT_W-1:0]  count_reg, count_next;
    edge_rect_t        top_reg, top_next;
    edge_rect_t        below_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;

    logic              take;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    edge_rect_t        base;
    edge_rect_t        cur;
    edge_rect_t        n_rect;
    edge_rect_t        o_rect;
    logic              push_room;

    logic signed [SUM_W-1:0] cl, ct, cr, cb;
    logic signed [SUM_W-1:0] nl, nt, nr_raw, nb_raw, nr, nb;
    logic signed [SUM_W-1:0] px1, py1;

    assign take  = !q_status.empty && (!out_valid_reg || m_ready);
    assign q_pop = take;

    assign base = '{l: '0, t: '0, r: screen.width, b: screen.height};
    assign cur  = (count_reg <= CNT_W'(1)) ? base : top_reg;

    assign cl = {2'b00, cur.l};
    assign ct = {2'b00, cur.t};
    assign cr = {2'b00, cur.r};
    assign cb = {2'b00, cur.b};

    assign nl     = (cmd.x > cl) ? cmd.x : cl;
    assign nt     = (cmd.y > ct) ? cmd.y : ct;
    assign nr_raw = (cmd.x2 < cr) ? cmd.x2 : cr;
    assign nb_raw = (cmd.y2 < cb) ? cmd.y2 : cb;
    assign nr     = (nr_raw < nl) ? nl : nr_raw;
    assign nb     = (nb_raw < nt) ? nt : nb_raw;
    assign px1    = cmd.x + signed'(SUM_W'(1));
    assign py1    = cmd.y + signed'(SUM_W'(1));

    assign n_rect = '{l: nl[EDGE_W-1:0], t: nt[EDGE_W-1:0],
                      r: nr[EDGE_W-1:0], b: nb[EDGE_W-1:0]};
    assign push_room = (count_reg < CNT_W'(CLIP_DEPTH));
    assign raddr     = ADDR_W'(count_next - CNT_W'(3));

    always_comb begin
        count_next = count_reg;
        top_next   = top_reg;
        we         = 1'b0;
        waddr      = ADDR_W'(count_reg - CNT_W'(2));
        o_rect     = '0;
        out_next   = '0;
        if (take) begin
            case (cmd.op)
                OP_PUSH: begin
                    out_next.hit = 1'b1;
                    o_rect       = cur;
                    if (push_room) begin
                        count_next = count_reg + 1'b1;
                        top_next   = n_rect;
                        o_rect     = n_rect;
                        we         = (count_reg > CNT_W'(1));
                    end
                end
                OP_POP: begin
                    out_next.hit = 1'b1;
                    o_rect       = base;
                    if (count_reg > CNT_W'(1)) begin
                        count_next = count_reg - 1'b1;
                    end
                    if (count_reg > CNT_W'(2)) begin
                        top_next = below_reg;
                        o_rect   = below_reg;
                    end
                end
                OP_VISIBLE: begin
                    if (cmd.x < cr && cmd.x2 > cl && cmd.y < cb && cmd.y2 > ct) begin
                        out_next.hit = 1'b1;
                        o_rect       = n_rect;
                    end
                end
                OP_PIXEL: begin
                    if (cmd.x >= cl && cmd.x < cr && cmd.y >= ct && cmd.y < cb) begin
                        out_next.hit = 1'b1;
                        o_rect       = '{l: cmd.x[EDGE_W-1:0], t: cmd.y[EDGE_W-1:0],
                                         r: px1[EDGE_W-1:0], b: py1[EDGE_W-1:0]};
                        out_next.ca  = cmd.ca;
                    end
                end
                OP_FILL, OP_DITHER: begin
                    if (nl < nr_raw && nt < nb_raw) begin
                        out_next.hit = 1'b1;
                        o_rect       = n_rect;
                        out_next.ca  = cmd.ca;
                        if (cmd.op == OP_DITHER) begin
                            out_next.cb   = cmd.cb;
                            out_next.dith = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        out_next.l     = o_rect.l[OUT_EDGE_W-1:0];
        out_next.t     = o_rect.t[OUT_EDGE_W-1:0];
        out_next.r     = o_rect.r[OUT_EDGE_W-1:0];
        out_next.b     = o_rect.b[OUT_EDGE_W-1:0];
        out_next.depth = DEPTH_OUT_W'(count_next);
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (take) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (take) begin
            out_reg <= out_next;
        end
    end

    // keep the entry below the top ready, forwarding a write to the same slot
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= top_reg;
        end
        below_reg <= (we && waddr == raddr) ? top_reg : mem[raddr];
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule

FILE: rtl/core/clip_stack_rect_clipper.sv
// A word accepted on s_ is stored in the queue, then in the output register, before it appears on m_.
// Throughput: one word per cycle while m_tready is high, set by the stack update in the back stage.
// A two-word queue sits between decode and execute; the output register holds a stalled result.
// Reset: depth returns to one (screen rectangle only), screen becomes 1024 x 768,
// queue and output register empty. Stored clip entries are not cleared.
module clip_stack_rect_clipper #(
    parameter int CLIP_DEPTH = csrc_pkg::DEF_CLIP_DEPTH,
    parameter int MAX_WIDTH  = csrc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = csrc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x, pos_y, size_w, size_h, color_a, color_b, zero pad
    input  logic [csrc_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic [csrc_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // hit, rect_left, rect_top, rect_right, rect_bottom, out_color_a, out_color_b,
    // stack_depth, zero pad
    output logic [csrc_pkg::M_TDATA_W-1:0]  m_tdata,
    // dither_on
    output logic [csrc_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [csrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csrc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import csrc_pkg::*;

    logic [SCR_W_W-1:0] scr_w_reg;
    logic [SCR_H_W-1:0] scr_h_reg;
    screen_t            screen;
    q_status_t          q_status;
    logic               q_push;
    logic               q_pop;
    cmd_t               in_cmd;
    cmd_t               head_cmd;
    logic               res_valid;
    result_t            res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scr_w_reg <= SCR_W_RESET;
            scr_h_reg <= SCR_H_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_SCREEN_WIDTH) begin
                scr_w_reg <= cfg_data;
            end else if (cfg_index == CFG_SCREEN_HEIGHT) begin
                scr_h_reg <= cfg_data[SCR_H_W-1:0];
            end
        end
    end

    // saturate the screen to the supported size
    assign screen.width  = (EDGE_W'(scr_w_reg) > EDGE_W'(MAX_WIDTH)) ?
                           EDGE_W'(MAX_WIDTH) : EDGE_W'(scr_w_reg);
    assign screen.height = (EDGE_W'(scr_h_reg) > EDGE_W'(MAX_HEIGHT)) ?
                           EDGE_W'(MAX_HEIGHT) : EDGE_W'(scr_h_reg);

    csrc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .q_push   (q_push),
        .q_cmd    (in_cmd)
    );

    csrc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (in_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    csrc_back #(
        .CLIP_DEPTH (CLIP_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .screen   (screen),
        .q_status (q_status),
        .cmd      (head_cmd),
        .q_pop    (q_pop),
        .m_valid  (res_valid),
        .m_ready  (m_tready),
        .m_result (res)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {3'b000, res.depth, res.cb, res.ca, res.b, res.r, res.t, res.l, res.hit};
    assign m_tuser  = res.dith;

endmodule

FILE: rtl/core/csrc_checker.sv
`include "clip_stack_rect_clipper_assert.svh"

module csrc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [csrc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [csrc_pkg::M_TUSER_W-1:0] m_tuser
);
    import csrc_pkg::*;

    `CSRC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    `CSRC_ASSERT_NOW(a_miss_zero, m_tvalid && !m_tdata[0], m_tdata[112:1] == '0 && m_tuser == '0, "miss carries non-zero rectangle or colour")

    `CSRC_ASSERT_NOW(a_dither_hit, m_tvalid && m_tuser[0], m_tdata[0], "dither flagged without a hit")

    `CSRC_ASSERT_NOW(a_colour_b, m_tvalid && !m_tuser[0], m_tdata[112:81] == '0, "colour b given without dither")

endmodule

bind clip_stack_rect_clipper csrc_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import csrc_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 9;
    localparam int IDLE_PCT     = 28;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    localparam logic [REQ_W-1:0]     REQ_RSVD6 = 3'd6;
    localparam logic [REQ_W-1:0]     REQ_RSVD7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_RSVD2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RSVD3 = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]          req;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] w;
        logic signed [COORD_W-1:0] h;
        logic [COLOR_W-1:0]        ca;
        logic [COLOR_W-1:0]        cb;
    } draw_cmd_t;

    typedef struct packed {
        draw_cmd_t cmd;
        bit        typed_exp;
        result_t   res;
    } stim_row_t;

    typedef struct {
        int l;
        int t;
        int r;
        int b;
    } clip_rect_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int         scr_w      = 1024;
    int         scr_h      = 768;
    int         clip_count = 1;
    clip_rect_t clip_stack [DEF_CLIP_DEPTH-1];

    result_t   exp_q [$];
    stim_row_t stim_rows [$];
    int        fail_count = 0;
    bit        no_idle    = 1'b0;
    bit        hold_arm   = 1'b0;
    bit        hold_done  = 1'b0;
    int        hold_left  = 0;

    clip_stack_rect_clipper u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic int imax(int a, int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int imin(int a, int b);
        return (a < b) ? a : b;
    endfunction

    function automatic clip_rect_t top_clip();
        clip_rect_t c;
        if (clip_count <= 1) begin
            c.l = 0;
            c.t = 0;
            c.r = imin(scr_w, DEF_MAX_WIDTH);
            c.b = imin(scr_h, DEF_MAX_HEIGHT);
        end else begin
            c = clip_stack[clip_count - 2];
        end
        return c;
    endfunction

    function automatic result_t predict_clip(draw_cmd_t c);
        clip_rect_t top;
        clip_rect_t n;
        clip_rect_t o;
        result_t    res;
        int         x;
        int         y;
        int         x2;
        int         y2;
        bit         hit;
        top = top_clip();
        x   = c.x;
        y   = c.y;
        x2  = x + int'(c.w);
        y2  = y + int'(c.h);
        o   = '{0, 0, 0, 0};
        res = '0;
        hit = 1'b0;
        n.l = imax(x, top.l);
        n.t = imax(y, top.t);
        n.r = imin(x2, top.r);
        n.b = imin(y2, top.b);
        case (c.req)
            REQ_PUSH: begin
                if (n.r < n.l) n.r = n.l;
                if (n.b < n.t) n.b = n.t;
                if (clip_count < DEF_CLIP_DEPTH) begin
                    clip_stack[clip_count - 1] = n;
                    clip_count++;
                end
                hit = 1'b1;
                o = top_clip();
            end
            REQ_POP: begin
                if (clip_count > 1) clip_count--;
                hit = 1'b1;
                o = top_clip();
            end
            REQ_VISIBLE: begin
                hit = x < top.r && x2 > top.l && y < top.b && y2 > top.t;
                if (hit) begin
                    o.l = n.l;
                    o.t = n.t;
                    o.r = imax(n.r, n.l);
                    o.b = imax(n.b, n.t);
                end
            end
            REQ_PIXEL: begin
                hit = x >= top.l && x < top.r && y >= top.t && y < top.b;
                if (hit) begin
                    o = '{x, y, x + 1, y + 1};
                    res.ca = c.ca;
                end
            end
            REQ_FILL, REQ_DITHER: begin
                hit = n.l < n.r && n.t < n.b;
                if (hit) begin
                    o = n;
                    res.ca = c.ca;
                    if (c.req == REQ_DITHER) begin
                        res.cb   = c.cb;
                        res.dith = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        res.hit   = hit;
        res.l     = 12'(o.l);
        res.t     = 12'(o.t);
        res.r     = 12'(o.r);
        res.b     = 12'(o.b);
        res.depth = 4'(clip_count);
        return res;
    endfunction

    function automatic void add_row(logic [REQ_W-1:0] req, int x, int y, int w, int h,
                                    logic [COLOR_W-1:0] ca = '0, logic [COLOR_W-1:0] cb = '0,
                                    bit typed_exp = 1'b0, result_t res = '0);
        stim_row_t row;
        row.cmd.req   = req;
        row.cmd.x     = 13'(x);
        row.cmd.y     = 13'(y);
        row.cmd.w     = 13'(w);
        row.cmd.h     = 13'(h);
        row.cmd.ca    = ca;
        row.cmd.cb    = cb;
        row.typed_exp = typed_exp;
        row.res       = res;
        stim_rows.push_back(row);
    endfunction

    function automatic draw_cmd_t random_cmd();
        draw_cmd_t  c;
        clip_rect_t top;
        int         pick;
        top  = top_clip();
        pick = $urandom_range(0, 99);
        if (pick < 16) c.req = REQ_PUSH;
        else if (pick < 32) c.req = REQ_POP;
        else if (pick < 47) c.req = REQ_VISIBLE;
        else if (pick < 63) c.req = REQ_PIXEL;
        else if (pick < 78) c.req = REQ_FILL;
        else if (pick < 94) c.req = REQ_DITHER;
        else if (pick < 97) c.req = REQ_RSVD6;
        else c.req = REQ_RSVD7;
        c.ca = $urandom();
        c.cb = $urandom();
        if ($urandom_range(0, 9) == 0) begin
            c.x = 13'($urandom());
            c.y = 13'($urandom());
            c.w = 13'($urandom());
            c.h = 13'($urandom());
        end else begin
            c.x = 13'(int'($urandom_range(0, 1100)) - 40);
            c.y = 13'(int'($urandom_range(0, 820)) - 40);
            c.w = 13'(int'($urandom_range(0, 700)) - 20);
            c.h = 13'(int'($urandom_range(0, 520)) - 20);
            if (c.req == REQ_PIXEL && $urandom_range(0, 1) == 1) begin
                c.x = 13'(top.l - 1 + int'($urandom_range(0, top.r - top.l + 1)));
                c.y = 13'(top.t - 1 + int'($urandom_range(0, top.b - top.t + 1)));
            end
        end
        return c;
    endfunction

    function automatic string fmt_result(result_t r);
        return $sformatf("hit=%0d rect=(%0d,%0d,%0d,%0d) a=%h b=%h dither=%0d depth=%0d",
                         r.hit, r.l, r.t, r.r, r.b, r.ca, r.cb, r.dith, r.depth);
    endfunction

    task automatic send_cmd(draw_cmd_t c, bit typed_exp, result_t res);
        result_t guess;
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.req;
        s_tdata  <= {4'd0, c.cb, c.ca, c.h, c.w, c.y, c.x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        guess = predict_clip(c);
        exp_q.push_back(typed_exp ? res : guess);
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) begin
            send_cmd(random_cmd(), 1'b0, '0);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (exp_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_screen(int w, int h, bit stray);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        int                    n;
        idx[0] = CFG_SCREEN_WIDTH;
        val[0] = 11'(w);
        idx[1] = CFG_SCREEN_HEIGHT;
        val[1] = 11'(h);
        idx[2] = CFG_RSVD2;
        val[2] = 11'($urandom());
        idx[3] = CFG_RSVD3;
        val[3] = 11'($urandom());
        n = stray ? 4 : 2;
        for (int i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            if (idx[i] == CFG_SCREEN_WIDTH) begin
                scr_w = int'(val[i]);
            end else if (idx[i] == CFG_SCREEN_HEIGHT) begin
                scr_h = int'(val[i][SCR_H_W-1:0]);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin : result_rx
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[0], m_tdata[12:1], m_tdata[24:13], m_tdata[36:25],
                    m_tdata[48:37], m_tdata[80:49], m_tdata[112:81], m_tuser[0],
                    m_tdata[116:113]};
            if (exp_q.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected result word: %s", fmt_result(got));
                end
            end else begin
                want = exp_q.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("result mismatch: expected %s", fmt_result(want));
                        $display("                 actual   %s", fmt_result(got));
                    end
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
        end else if (hold_arm && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        m_tready <= (hold_left == 0) && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("clip_stack_rect_clipper regression: fail");
        $finish;
    end

    initial begin
        add_row(REQ_POP, 0, 0, 0, 0, '0, '0, 1'b1,
                '{1'b1, 12'd0, 12'd0, 12'd1024, 12'd768, 32'd0, 32'd0, 1'b0, 4'd1});
        add_row(REQ_FILL, 0, 0, 1024, 768, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1,
                '{1'b1, 12'd0, 12'd0, 12'd1024, 12'd768, 32'hFFFF_FFFF, 32'd0, 1'b0, 4'd1});
        add_row(REQ_DITHER, -4096, -4096, 4095, 4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                '{1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 32'd0, 1'b0, 4'd1});
        add_row(REQ_DITHER, 0, 0, 4095, 4095, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1,
                '{1'b1, 12'd0, 12'd0, 12'd1024, 12'd768, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                  1'b1, 4'd1});
        add_row(REQ_PIXEL, 1023, 767, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1,
                '{1'b1, 12'd1023, 12'd767, 12'd1024, 12'd768, 32'h0000_0001, 32'd0,
                  1'b0, 4'd1});
        add_row(REQ_PIXEL, 1024, 0, 0, 0, 32'h0000_0002, 32'd0, 1'b1,
                '{1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 32'd0, 1'b0, 4'd1});
        add_row(REQ_PIXEL, -1, 0, 0, 0, 32'h0000_0003, 32'd0, 1'b1,
                '{1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 32'd0, 1'b0, 4'd1});
        add_row(REQ_VISIBLE, 4095, 4095, -4096, -4096, 32'd0, 32'd0, 1'b1,
                '{1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 32'd0, 1'b0, 4'd1});
        add_row(REQ_VISIBLE, -10, -10, 20, 20, 32'h1111_1111, 32'h2222_2222, 1'b1,
                '{1'b1, 12'd0, 12'd0, 12'd10, 12'd10, 32'd0, 32'd0, 1'b0, 4'd1});
        add_row(REQ_RSVD6, 5, 5, 5, 5, 32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b1,
                '{1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 32'd0, 1'b0, 4'd1});
        add_row(REQ_RSVD7, 5, 5, 5, 5, 32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b1,
                '{1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 32'd0, 1'b0, 4'd1});
        add_row(REQ_PUSH, 100, 50, 200, 100, '0, '0, 1'b1,
                '{1'b1, 12'd100, 12'd50, 12'd300, 12'd150, 32'd0, 32'd0, 1'b0, 4'd2});
        add_row(REQ_PUSH, 120, 60, -5, 0, '0, '0, 1'b1,
                '{1'b1, 12'd120, 12'd60, 12'd120, 12'd60, 32'd0, 32'd0, 1'b0, 4'd3});
        add_row(REQ_FILL, 0, 0, 4095, 4095, 32'h7777_7777, 32'd0, 1'b1,
                '{1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 32'd0, 32'd0, 1'b0, 4'd3});
        add_row(REQ_POP, 0, 0, 0, 0, '0, '0, 1'b1,
                '{1'b1, 12'd100, 12'd50, 12'd300, 12'd150, 32'd0, 32'd0, 1'b0, 4'd2});
        repeat (5) add_row(REQ_PUSH, 0, 0, 4095, 4095);
        add_row(REQ_PUSH, -4096, -4096, 4095, 4095);
        add_row(REQ_PUSH, 150, 60, 10, 10);
        add_row(REQ_DITHER, 90, 40, 30, 30, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        add_row(REQ_POP, 0, 0, 0, 0);
        add_row(REQ_VISIBLE, 100, 50, 1, 1);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i]) begin
            send_cmd(stim_rows[i].cmd, stim_rows[i].typed_exp, stim_rows[i].res);
        end
        run_random(150);
        wait_drained();

        set_screen(0, 0, 1'b0);
        run_random(100);
        wait_drained();

        set_screen(2047, 1023, 1'b1);
        hold_arm <= 1'b1;
        run_random(200);
        wait_drained();

        set_screen(1, 1, 1'b0);
        run_random(100);
        wait_drained();

        set_screen(int'($urandom_range(0, 2047)), int'($urandom_range(0, 2047)), 1'b1);
        no_idle <= 1'b1;
        run_random(200);
        wait_drained();
        no_idle <= 1'b0;

        set_screen(640, 480, 1'b0);
        run_random(320);
        wait_drained();

        fail_count += exp_q.size();
        if (fail_count == 0) begin
            $display("clip_stack_rect_clipper regression: pass");
        end else begin
            $display("clip_stack_rect_clipper regression: fail");
        end
        $finish;
    end

endmodule
